// ===== sv/b64_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Base64 codec package
// Shared job type, queue depth, pad character and alphabet mapping functions.
// ---------------------------------------------------------------------------
package b64_pkg;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // What the back end does with one queued group
    typedef enum logic [1:0] {
        JOB_ENCODE = 2'd0,
        JOB_DECODE = 2'd1,
        JOB_ERROR  = 2'd2
    } job_kind_t;

    // One group handed from front to back.
    // nreal: characters from data when encoding (2..4), bytes when decoding (1..3)
    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  nreal;
        logic        last;
        logic [23:0] bits;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    // Map an ASCII character to its sixtet; anything outside the alphabet gives 0
    function automatic logic [5:0] sixtet_of(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                t = c - 8'd65;
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                t = c - 8'd71;
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                t = c + 8'd4;
            end
            else if (c == 8'h2B)
            begin
                t = 8'd62;
            end
            else if (c == 8'h2F)
            begin
                t = 8'd63;
            end
            return t[5:0];
        end
    endfunction

    // Map a sixtet to its alphabet character
    function automatic logic [7:0] char_of(input logic [5:0] s);
        logic [7:0] w;
        begin
            w = {2'b00, s};
            if (s < 6'd26)
            begin
                return w + 8'd65;
            end
            else if (s < 6'd52)
            begin
                return w + 8'd71;
            end
            else if (s < 6'd62)
            begin
                return w - 8'd4;
            end
            else if (s == 6'd62)
            begin
                return 8'h2B;
            end
            return 8'h2F;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/b64_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Base64 job queue
// Small register FIFO that lets the front and back stall independently.
// ---------------------------------------------------------------------------
module b64_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/b64_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Base64 front end
// Accepts input beats, gathers groups and queues one job per finished group.
// ---------------------------------------------------------------------------
module b64_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_data,
    input  wire logic         in_valid,
    input  wire logic [7:0]   in_value,
    input  wire logic         in_last,
    output logic              in_ready,
    output logic              job_push,
    output b64_pkg::job_t     job,
    input  wire logic         job_full
);
    import b64_pkg::*;

    logic        direction_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [23:0] bits_reg, bits_next;
    logic        third_pad_reg, third_pad_next;

    logic        accept;
    logic        is_pad;
    logic [5:0]  sixtet;
    logic [23:0] merged;

    assign in_ready = !job_full;
    assign accept   = in_valid && in_ready;
    assign is_pad   = (in_value == PAD_CHAR);
    assign sixtet   = is_pad ? 6'd0 : sixtet_of(in_value);

    // Place the new element into the group word
    always_comb
    begin
        merged = bits_reg;
        if (!direction_reg)
        begin
            case (pos_reg)
                2'd0:    merged = bits_reg | {in_value, 16'd0};
                2'd1:    merged = bits_reg | {8'd0, in_value, 8'd0};
                2'd2:    merged = bits_reg | {16'd0, in_value};
                default: merged = bits_reg;
            endcase
        end
        else
        begin
            case (pos_reg)
                2'd0:    merged = bits_reg | {sixtet, 18'd0};
                2'd1:    merged = bits_reg | {6'd0, sixtet, 12'd0};
                2'd2:    merged = bits_reg | {12'd0, sixtet, 6'd0};
                default: merged = bits_reg | {18'd0, sixtet};
            endcase
        end
    end

    // Decide whether the group closes and build its job
    always_comb
    begin
        pos_next       = pos_reg;
        bits_next      = bits_reg;
        third_pad_next = third_pad_reg;
        job_push       = 1'b0;
        job.kind       = direction_reg ? JOB_DECODE : JOB_ENCODE;
        job.nreal      = 3'd4;
        job.last       = in_last;
        job.bits       = merged;
        if (accept)
        begin
            if (!direction_reg)
            begin
                if (pos_reg < 2'd2 && !in_last)
                begin
                    pos_next  = pos_reg + 2'd1;
                    bits_next = merged;
                end
                else
                begin
                    job_push       = 1'b1;
                    job.nreal      = {1'b0, pos_reg} + 3'd2;
                    pos_next       = 2'd0;
                    bits_next      = '0;
                    third_pad_next = 1'b0;
                end
            end
            else if (pos_reg != 2'd3)
            begin
                if (in_last)
                begin
                    // Message ended off a four-character boundary
                    job_push       = 1'b1;
                    job.kind       = JOB_ERROR;
                    job.nreal      = 3'd1;
                    job.last       = 1'b1;
                    pos_next       = 2'd0;
                    bits_next      = '0;
                    third_pad_next = 1'b0;
                end
                else
                begin
                    pos_next  = pos_reg + 2'd1;
                    bits_next = merged;
                    if (pos_reg == 2'd2)
                    begin
                        third_pad_next = is_pad;
                    end
                end
            end
            else
            begin
                // Full group: padding trims bytes only in the final group
                job_push = 1'b1;
                if (in_last)
                begin
                    job.nreal = 3'd3 - {2'b00, is_pad} - {2'b00, third_pad_reg};
                end
                else
                begin
                    job.nreal = 3'd3;
                end
                pos_next       = 2'd0;
                bits_next      = '0;
                third_pad_next = 1'b0;
            end
        end
    end

    // Hold mode and group state; a mode write drops any partial group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            pos_reg       <= '0;
            bits_reg      <= '0;
            third_pad_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            direction_reg <= cfg_data;
            pos_reg       <= '0;
            bits_reg      <= '0;
            third_pad_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            bits_reg      <= bits_next;
            third_pad_reg <= third_pad_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/b64_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Base64 back end
// Takes queued jobs and emits a result beat per cycle while out_ready allows.
// ---------------------------------------------------------------------------
module b64_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         job_avail,
    input  wire b64_pkg::job_t job_in,
    output logic              job_pop,
    output logic              out_valid,
    output logic [7:0]        out_value,
    output logic              out_last,
    output logic              out_status,
    input  wire logic         out_ready
);
    import b64_pkg::*;

    job_t        job_reg;
    logic        job_valid_reg;
    logic [1:0]  k_reg;
    logic        out_valid_reg;
    logic [7:0]  value_reg;
    logic        last_reg;
    logic        status_reg;

    logic        out_free;
    logic        advance;
    logic        final_beat;
    logic [2:0]  total;
    logic [5:0]  sixtet;
    logic [7:0]  beat_value;
    logic        take;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = job_valid_reg && out_free;

    // Count of beats in the current job
    always_comb
    begin
        case (job_reg.kind)
            JOB_ENCODE: total = 3'd4;
            JOB_DECODE: total = job_reg.nreal;
            JOB_ERROR:  total = 3'd1;
            default:    total = 3'd1;
        endcase
    end

    assign final_beat = ({1'b0, k_reg} + 3'd1 == total);
    assign take       = job_avail && (!job_valid_reg || (advance && final_beat));
    assign job_pop    = take;

    // Select the beat's value
    always_comb
    begin
        case (k_reg)
            2'd0:    sixtet = job_reg.bits[23:18];
            2'd1:    sixtet = job_reg.bits[17:12];
            2'd2:    sixtet = job_reg.bits[11:6];
            default: sixtet = job_reg.bits[5:0];
        endcase
        case (job_reg.kind)
            JOB_ENCODE:
            begin
                beat_value = ({1'b0, k_reg} < job_reg.nreal) ? char_of(sixtet) : PAD_CHAR;
            end
            JOB_DECODE:
            begin
                case (k_reg)
                    2'd0:    beat_value = job_reg.bits[23:16];
                    2'd1:    beat_value = job_reg.bits[15:8];
                    2'd2:    beat_value = job_reg.bits[7:0];
                    default: beat_value = 8'd0;
                endcase
            end
            default:    beat_value = 8'd0;
        endcase
    end

    // Step through the current job and fetch the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                job_valid_reg <= 1'b1;
                k_reg         <= '0;
            end
            else if (advance)
            begin
                if (final_beat)
                begin
                    job_valid_reg <= 1'b0;
                    k_reg         <= '0;
                end
                else
                begin
                    k_reg <= k_reg + 2'd1;
                end
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load job and output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_in;
        end
        if (advance)
        begin
            value_reg  <= beat_value;
            last_reg   <= final_beat && job_reg.last;
            status_reg <= (job_reg.kind == JOB_ERROR);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = value_reg;
    assign out_last   = last_reg;
    assign out_status = status_reg;

endmodule
`default_nettype wire

// ===== sv/base64_stream_codec_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Base64 stream codec
// Encodes bytes to Base64 text or decodes text to bytes, set by a mode register.
// ---------------------------------------------------------------------------
//  channel | signals                        | contents
//  --------+--------------------------------+----------------------------------
//  cfg     | cfg_valid cfg_ready cfg_data   | mode: 0 encode, 1 decode
//  s (in)  | s_tvalid s_tready s_tdata      | tdata[7:0] byte or character,
//          | s_tlast                        | tlast marks end of message
//  m (out) | m_tvalid m_tready m_tdata      | tdata[7:0] character or byte,
//          | m_tlast m_tuser                | tuser[0] length error
//
//  The front takes one input beat per cycle while the job queue is not full;
//  the back emits one result beat per cycle while m_tready does not stall it.
//  A closed group's job is queued, then loaded into the back's job register,
//  which then registers its first result beat. The job queue holds QueueDepth
//  groups and s_tready falls only while it is full. Reset clears mode to encode
//  and drops any partial group; so does a mode write. cfg_ready is always high.
// ---------------------------------------------------------------------------
module base64_stream_codec_top #(
    parameter int QueueDepth = b64_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,      // [0] direction
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] in_value
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // [7:0] out_value
    output logic            m_tlast,
    output logic            m_tuser        // [0] status
);
    import b64_pkg::*;

    job_t             push_job;
    job_t             pop_job;
    logic [JOB_W-1:0] pop_bits;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_avail;

    assign cfg_ready = 1'b1;

    // Accept and group input beats
    b64_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .in_valid (s_tvalid),
        .in_value (s_tdata),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .job_push (q_push),
        .job      (push_job),
        .job_full (q_full)
    );

    // Queue finished groups
    b64_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (pop_bits),
        .not_empty(q_avail)
    );

    assign pop_job = job_t'(pop_bits);

    // Emit result beats
    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (q_avail),
        .job_in    (pop_job),
        .job_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_value (m_tdata),
        .out_last  (m_tlast),
        .out_status(m_tuser),
        .out_ready (m_tready)
    );

    // An error beat is always zero and closes the message
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("error beat not zero or not last");

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue overflow");

    // A popped job always comes from a non-empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_avail)
        else $error("job queue underflow");

    // A stalled result beat holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

endmodule
`default_nettype wire
